@@ design/serdes_sample_phase_adapt_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sampling-phase adaptation core
// Shared property wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERDES_SAMPLE_PHASE_ADAPT_CORE_DEFINES_SVH
`define SERDES_SAMPLE_PHASE_ADAPT_CORE_DEFINES_SVH

// Same-cycle implication
`define SSPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SSPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sspa_pkg.sv @@
// ----------------------------------------------------------------------------
// Sampling-phase adaptation package
// Item types, register indexes and fixed constants of the phase adapter.
// ----------------------------------------------------------------------------
package sspa_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPTIMAL_F0B   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_LOW_PCT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_HIGH_PCT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_F1_STRONG     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_F1_WEAK       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_MIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_MAX     = 3'd7;

  // Limit status codes
  localparam logic [1:0] LIMIT_NONE   = 2'd0;
  localparam logic [1:0] LIMIT_AT_MIN = 2'd1;
  localparam logic [1:0] LIMIT_AT_MAX = 2'd2;

  // Divide by 100 as multiply by ceil(2^19/100) and shift; exact below 43690
  localparam int          PCT_SHIFT = 19;
  localparam logic [12:0] PCT_RECIP = 13'd5243;

  localparam logic PHASE_FLAG = 1'b1;

  localparam logic [5:0] LOOP_COUNT_RST = 6'd1;
  localparam logic [6:0] PHASE_MAX_RST  = 7'd127;

  typedef struct packed {
    logic signed [7:0] precursor_tap;
    logic signed [7:0] postcursor_tap;
    logic        [6:0] current_phase;
  } in_item_t;

  typedef struct packed {
    logic       decision_made;
    logic [7:0] phase_word;
    logic [1:0] limit_status;
  } out_item_t;

endpackage

@@ design/serdes_sample_phase_adapt_core.sv @@
// ----------------------------------------------------------------------------
// Sampling-phase adaptation core
// Accumulates tracking-DFE taps over a window and steps the sampling phase.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result
//   register; decision and state update in stage two.
// Throughput: 1 item per cycle while the result side keeps taking items.
// Reset: synchronous, active low; restores register defaults, clears sums,
//   loop counter and threshold latch, and empties both pipeline registers.
`include "serdes_sample_phase_adapt_core_defines.svh"

module serdes_sample_phase_adapt_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sspa_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sspa_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [sspa_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [sspa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic        [6:0] f0b_r, f0b_nxt;
  logic        [7:0] hlo_r, hlo_nxt;
  logic        [7:0] hhi_r, hhi_nxt;
  logic        [5:0] lc_r, lc_nxt;
  logic signed [7:0] f1s_r, f1s_nxt;
  logic signed [7:0] f1w_r, f1w_nxt;
  logic        [6:0] pmin_r, pmin_nxt;
  logic        [6:0] pmax_r, pmax_nxt;

  // Threshold precompute
  logic         [14:0] prod_lo_r, prod_hi_r;
  logic         [27:0] quot_lo_full, quot_hi_full;
  logic          [7:0] quot_lo_r, quot_hi_r;
  logic signed  [14:0] strong_sc_r, weak_sc_r;

  // Pipeline
  logic                in_vld_r;
  sspa_pkg::in_item_t  in_r;
  logic                out_vld_r;
  sspa_pkg::out_item_t out_r, out_nxt;
  logic                adv;

  // Adapter state
  logic                started_r;
  logic          [5:0] cnt_r, cnt_nxt, cnt_base;
  logic signed  [15:0] sum_pre_r, sum_post_r, sum_pre_nxt, sum_post_nxt;
  logic signed  [15:0] sum_pre_base, sum_post_base;
  logic          [7:0] lthr_r, hthr_r, lthr, hthr;

  // Decision path
  logic signed  [16:0] pre_add, post_add;
  logic signed  [15:0] sp, sq;
  logic         [13:0] thr_lo_u, thr_hi_u;
  logic signed  [16:0] sp_x, sq_x, thr_lo, thr_hi, thr_strong, thr_weak;
  logic                close_win, go_down, go_up;
  logic          [6:0] ph_new;
  logic          [1:0] limit;

  always_comb begin
    f0b_nxt  = f0b_r;
    hlo_nxt  = hlo_r;
    hhi_nxt  = hhi_r;
    lc_nxt   = lc_r;
    f1s_nxt  = f1s_r;
    f1w_nxt  = f1w_r;
    pmin_nxt = pmin_r;
    pmax_nxt = pmax_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        sspa_pkg::REG_OPTIMAL_F0B:   f0b_nxt  = cfg_wdata[6:0];
        sspa_pkg::REG_HYST_LOW_PCT:  hlo_nxt  = cfg_wdata;
        sspa_pkg::REG_HYST_HIGH_PCT: hhi_nxt  = cfg_wdata;
        sspa_pkg::REG_LOOP_COUNT:    lc_nxt   = cfg_wdata[5:0];
        sspa_pkg::REG_F1_STRONG:     f1s_nxt  = cfg_wdata;
        sspa_pkg::REG_F1_WEAK:       f1w_nxt  = cfg_wdata;
        sspa_pkg::REG_PHASE_MIN:     pmin_nxt = cfg_wdata[6:0];
        sspa_pkg::REG_PHASE_MAX:     pmax_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign quot_lo_full = 28'(prod_lo_r) * 28'(sspa_pkg::PCT_RECIP);
  assign quot_hi_full = 28'(prod_hi_r) * 28'(sspa_pkg::PCT_RECIP);

  // Handshake
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    sum_pre_base  = started_r ? sum_pre_r  : 16'sd0;
    sum_post_base = started_r ? sum_post_r : 16'sd0;
    cnt_base      = started_r ? cnt_r      : 6'd0;
    lthr          = started_r ? lthr_r     : quot_lo_r;
    hthr          = started_r ? hthr_r     : quot_hi_r;

    // Saturating accumulate
    pre_add  = {sum_pre_base[15], sum_pre_base} + 17'(in_r.precursor_tap);
    post_add = {sum_post_base[15], sum_post_base} + 17'(in_r.postcursor_tap);
    if (pre_add[16] != pre_add[15]) begin
      sp = pre_add[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sp = pre_add[15:0];
    end
    if (post_add[16] != post_add[15]) begin
      sq = post_add[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sq = post_add[15:0];
    end

    close_win = (cnt_base >= lc_r);

    thr_lo_u   = 14'(lthr) * 14'(lc_r);
    thr_hi_u   = 14'(hthr) * 14'(lc_r);
    thr_lo     = $signed({3'b000, thr_lo_u});
    thr_hi     = $signed({3'b000, thr_hi_u});
    thr_strong = 17'(strong_sc_r);
    thr_weak   = 17'(weak_sc_r);
    sp_x       = 17'(sp);
    sq_x       = 17'(sq);

    go_down = (sp_x < thr_lo) && (sq_x >= thr_strong);
    go_up   = (sp_x > thr_hi) || ((sq_x <= thr_weak) && !sp[15] && (sp != 16'sd0));

    ph_new = in_r.current_phase;
    limit  = sspa_pkg::LIMIT_NONE;
    if (go_down) begin
      if (in_r.current_phase > pmin_r) begin
        ph_new = in_r.current_phase - 7'd1;
      end else begin
        limit = sspa_pkg::LIMIT_AT_MIN;
      end
    end else if (go_up) begin
      if (in_r.current_phase < pmax_r) begin
        ph_new = in_r.current_phase + 7'd1;
      end else begin
        limit = sspa_pkg::LIMIT_AT_MAX;
      end
    end

    if (close_win) begin
      out_nxt.decision_made = 1'b1;
      out_nxt.phase_word    = {sspa_pkg::PHASE_FLAG, ph_new};
      out_nxt.limit_status  = limit;
      sum_pre_nxt           = 16'sd0;
      sum_post_nxt          = 16'sd0;
      cnt_nxt               = 6'd0;
    end else begin
      out_nxt.decision_made = 1'b0;
      out_nxt.phase_word    = 8'd0;
      out_nxt.limit_status  = sspa_pkg::LIMIT_NONE;
      sum_pre_nxt           = sp;
      sum_post_nxt          = sq;
      cnt_nxt               = cnt_base + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0b_r       <= '0;
      hlo_r       <= '0;
      hhi_r       <= '0;
      lc_r        <= sspa_pkg::LOOP_COUNT_RST;
      f1s_r       <= '0;
      f1w_r       <= '0;
      pmin_r      <= '0;
      pmax_r      <= sspa_pkg::PHASE_MAX_RST;
      prod_lo_r   <= '0;
      prod_hi_r   <= '0;
      quot_lo_r   <= '0;
      quot_hi_r   <= '0;
      strong_sc_r <= '0;
      weak_sc_r   <= '0;
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      started_r   <= 1'b0;
      cnt_r       <= '0;
      sum_pre_r   <= '0;
      sum_post_r  <= '0;
      lthr_r      <= '0;
      hthr_r      <= '0;
    end else begin
      f0b_r  <= f0b_nxt;
      hlo_r  <= hlo_nxt;
      hhi_r  <= hhi_nxt;
      lc_r   <= lc_nxt;
      f1s_r  <= f1s_nxt;
      f1w_r  <= f1w_nxt;
      pmin_r <= pmin_nxt;
      pmax_r <= pmax_nxt;

      // Two-step threshold precompute; user must let it settle before stage two
      prod_lo_r   <= 15'(f0b_nxt) * 15'(hlo_nxt);
      prod_hi_r   <= 15'(f0b_nxt) * 15'(hhi_nxt);
      quot_lo_r   <= quot_lo_full[sspa_pkg::PCT_SHIFT+7:sspa_pkg::PCT_SHIFT];
      quot_hi_r   <= quot_hi_full[sspa_pkg::PCT_SHIFT+7:sspa_pkg::PCT_SHIFT];
      strong_sc_r <= 15'(f1s_nxt) * $signed(15'({1'b0, lc_nxt}));
      weak_sc_r   <= 15'(f1w_nxt) * $signed(15'({1'b0, lc_nxt}));

      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
        in_r     <= in_data;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end

      if (adv) begin
        out_vld_r  <= 1'b1;
        out_r      <= out_nxt;
        started_r  <= 1'b1;
        cnt_r      <= cnt_nxt;
        sum_pre_r  <= sum_pre_nxt;
        sum_post_r <= sum_post_nxt;
        if (!started_r) begin
          lthr_r <= quot_lo_r;
          hthr_r <= quot_hi_r;
        end
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  `SSPA_ASSERT_NOW(a_ready_when_out_empty, !out_vld_r, in_ready, "input blocked with empty result register")
  `SSPA_ASSERT_NEXT(a_started_sticks, started_r, started_r, "threshold latch dropped without reset")
  `SSPA_ASSERT_NOW(a_limit_needs_decision, out_vld_r && (out_r.limit_status != sspa_pkg::LIMIT_NONE), out_r.decision_made, "limit reported without decision")
  `SSPA_ASSERT_NOW(a_flag_on_decision, out_vld_r && out_r.decision_made, out_r.phase_word[7], "decision without phase flag")
  `SSPA_ASSERT_NEXT(a_window_restarts, adv && close_win, (cnt_r == 6'd0) && (sum_pre_r == 16'sd0), "window not cleared after decision")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sampling-phase adaptation core
// Streams tap items through the core under bursty input and a stalling
// result side, and checks every result against an in-bench model of the
// windowed tap sums, the latched fn1 thresholds and the clamped phase step.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PCT_DIVISOR    = 100;
  localparam int PHASE_ITEMS    = 210;
  localparam int NUM_PHASES     = 8;

  class phase_adapt_scoreboard;
    logic        [6:0] f0b_opt;
    logic        [7:0] pct_low;
    logic        [7:0] pct_high;
    logic        [5:0] loop_len;
    logic signed [7:0] f1_strong;
    logic signed [7:0] f1_weak;
    logic        [6:0] ph_min;
    logic        [6:0] ph_max;
    bit                latched;
    logic        [5:0] win_count;
    int                sum_fn1;
    int                sum_f1;
    logic        [7:0] thr_low;
    logic        [7:0] thr_high;
    sspa_pkg::out_item_t expected_q[$];
    int                errors;

    function new();
      f0b_opt   = '0;
      pct_low   = '0;
      pct_high  = '0;
      loop_len  = sspa_pkg::LOOP_COUNT_RST;
      f1_strong = '0;
      f1_weak   = '0;
      ph_min    = '0;
      ph_max    = sspa_pkg::PHASE_MAX_RST;
      latched   = 1'b0;
      win_count = '0;
      sum_fn1   = 0;
      sum_f1    = 0;
      thr_low   = '0;
      thr_high  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [sspa_pkg::CFG_IDX_W-1:0] idx,
                            logic [sspa_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sspa_pkg::REG_OPTIMAL_F0B:   f0b_opt   = val[6:0];
        sspa_pkg::REG_HYST_LOW_PCT:  pct_low   = val;
        sspa_pkg::REG_HYST_HIGH_PCT: pct_high  = val;
        sspa_pkg::REG_LOOP_COUNT:    loop_len  = val[5:0];
        sspa_pkg::REG_F1_STRONG:     f1_strong = val;
        sspa_pkg::REG_F1_WEAK:       f1_weak   = val;
        sspa_pkg::REG_PHASE_MIN:     ph_min    = val[6:0];
        sspa_pkg::REG_PHASE_MAX:     ph_max    = val[6:0];
        default: ;
      endcase
    endfunction

    function int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_input(sspa_pkg::in_item_t item);
      int                  lc;
      int                  lim_low;
      int                  lim_high;
      int                  lim_strong;
      int                  lim_weak;
      logic [6:0]          ph;
      logic [1:0]          limit;
      sspa_pkg::out_item_t res;
      ph    = item.current_phase;
      limit = sspa_pkg::LIMIT_NONE;
      res   = '0;
      // latch thresholds once, on the first item after reset
      if (!latched) begin
        win_count = '0;
        sum_fn1   = 0;
        sum_f1    = 0;
        latched   = 1'b1;
        thr_low   = 8'((int'(f0b_opt) * int'(pct_low)) / PCT_DIVISOR);
        thr_high  = 8'((int'(f0b_opt) * int'(pct_high)) / PCT_DIVISOR);
      end
      sum_fn1 = sat16(sum_fn1 + int'($signed(item.precursor_tap)));
      sum_f1  = sat16(sum_f1 + int'($signed(item.postcursor_tap)));
      if (win_count < loop_len) begin
        win_count = win_count + 6'd1;
        expected_q.push_back(res);
        return;
      end
      lc         = int'(loop_len);
      lim_low    = int'(thr_low) * lc;
      lim_high   = int'(thr_high) * lc;
      lim_strong = int'($signed(f1_strong)) * lc;
      lim_weak   = int'($signed(f1_weak)) * lc;
      if (sum_fn1 < lim_low && sum_f1 >= lim_strong) begin
        if (ph > ph_min) ph = ph - 7'd1;
        else limit = sspa_pkg::LIMIT_AT_MIN;
      end else if (sum_fn1 > lim_high || (sum_f1 <= lim_weak && sum_fn1 > 0)) begin
        if (ph < ph_max) ph = ph + 7'd1;
        else limit = sspa_pkg::LIMIT_AT_MAX;
      end
      sum_fn1   = 0;
      sum_f1    = 0;
      win_count = '0;
      res.decision_made = 1'b1;
      res.phase_word    = {sspa_pkg::PHASE_FLAG, ph};
      res.limit_status  = limit;
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(sspa_pkg::out_item_t got);
      sspa_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result item with none expected: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.decision_made !== want.decision_made)
        report_mismatch($sformatf("decision_made got %0b expected %0b",
                                  got.decision_made, want.decision_made));
      if (got.phase_word !== want.phase_word)
        report_mismatch($sformatf("phase_word got %h expected %h",
                                  got.phase_word, want.phase_word));
      if (got.limit_status !== want.limit_status)
        report_mismatch($sformatf("limit_status got %0d expected %0d",
                                  got.limit_status, want.limit_status));
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  sspa_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  sspa_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [sspa_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [sspa_pkg::CFG_DATA_W-1:0] cfg_wdata;

  phase_adapt_scoreboard sb;
  int                    stall_cycles;
  int                    ready_hold;
  int                    seg_left;
  int                    seg_style;

  serdes_sample_phase_adapt_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Track accepted items on both sides; give up when nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Result side: segments of steady, sparse, dense or toggling ready,
  // overridden by a long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    seg_left  = 0;
    seg_style = 0;
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        if (seg_left == 0) begin
          seg_style = $urandom_range(0, 3);
          seg_left  = $urandom_range(4, 50);
        end
        seg_left--;
        case (seg_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic write_cfg(logic [sspa_pkg::CFG_IDX_W-1:0] idx,
                           logic [sspa_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Hold the item until accepted; valid stays high for a back-to-back item.
  task automatic send_item(sspa_pkg::in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_taps(int fn1, int f1, int ph, int reps);
    sspa_pkg::in_item_t item;
    item.precursor_tap  = fn1[7:0];
    item.postcursor_tap = f1[7:0];
    item.current_phase  = ph[6:0];
    repeat (reps) send_item(item);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering items and wait until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] tap_near(int mid, int spread);
    int v;
    v = mid + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[7:0];
  endfunction

  function automatic int pick_val(int lo, int hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  // Bursts share a tap bias so that windows land on every decision branch.
  task automatic run_random(int n_items, bit no_gaps);
    int                 sent;
    int                 burst;
    int                 fn1_mid;
    int                 f1_mid;
    int                 spread;
    sspa_pkg::in_item_t item;
    sent = 0;
    while (sent < n_items) begin
      burst   = $urandom_range(1, 40);
      fn1_mid = int'($urandom_range(0, 255)) - 128;
      f1_mid  = int'($urandom_range(0, 255)) - 128;
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 3;
        2:       spread = 16;
        default: spread = 128;
      endcase
      while (burst > 0 && sent < n_items) begin
        item.precursor_tap  = tap_near(fn1_mid, spread);
        item.postcursor_tap = tap_near(f1_mid, spread);
        case ($urandom_range(0, 7))
          0:       item.current_phase = sb.ph_min;
          1:       item.current_phase = sb.ph_max;
          2:       item.current_phase = sb.ph_min - 7'd1;
          3:       item.current_phase = sb.ph_max + 7'd1;
          default: item.current_phase = 7'($urandom_range(0, 127));
        endcase
        send_item(item);
        sent++;
        burst--;
      end
      if (!no_gaps && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
  endtask

  initial begin
    int k;
    sb           = new();
    stall_cycles = 0;
    ready_hold   = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Thresholds latch on the first item: low 50, high 323 truncated to 67.
    write_cfg(sspa_pkg::REG_OPTIMAL_F0B, 8'd127);
    write_cfg(sspa_pkg::REG_HYST_LOW_PCT, 8'd40);
    write_cfg(sspa_pkg::REG_HYST_HIGH_PCT, 8'd255);
    write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'd1);
    write_cfg(sspa_pkg::REG_F1_STRONG, 8'd0);
    write_cfg(sspa_pkg::REG_F1_WEAK, 8'd0);
    write_cfg(sspa_pkg::REG_PHASE_MIN, 8'd0);
    write_cfg(sspa_pkg::REG_PHASE_MAX, 8'd127);
    cfg_we <= 1'b0;

    // Two-item windows: down at min, up at max, down, up on fn1, up on weak f1, hold
    send_taps(-128, 127, 0, 2);
    send_taps(127, -128, 127, 2);
    send_taps(10, 0, 64, 2);
    send_taps(40, -5, 64, 2);
    send_taps(30, -10, 64, 2);
    send_taps(30, 10, 64, 2);
    drain();

    // Phase outside the bounds: steps toward the violated bound are refused
    write_cfg(sspa_pkg::REG_PHASE_MIN, 8'd20);
    write_cfg(sspa_pkg::REG_PHASE_MAX, 8'd100);
    cfg_we <= 1'b0;
    send_taps(0, 0, 10, 2);
    send_taps(100, 0, 120, 2);
    drain();

    // Leave a window open, then shorten it so the next item closes it
    write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'd4);
    cfg_we <= 1'b0;
    send_taps(5, 5, 50, 3);
    drain();
    write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'd2);
    cfg_we <= 1'b0;
    send_taps(5, 5, 50, 1);
    drain();

    // Zero window length: every item decides against zero thresholds
    write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'd0);
    cfg_we <= 1'b0;
    send_taps(-3, 4, 60, 1);
    send_taps(2, 0, 60, 1);
    drain();

    for (k = 0; k < NUM_PHASES; k++) begin
      write_cfg(sspa_pkg::REG_OPTIMAL_F0B, 8'(pick_val(0, 127)));
      write_cfg(sspa_pkg::REG_HYST_LOW_PCT, 8'(pick_val(0, 255)));
      write_cfg(sspa_pkg::REG_HYST_HIGH_PCT, 8'(pick_val(0, 255)));
      if (k == 1) write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'd63);
      else if (k == 2) write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'd0);
      else write_cfg(sspa_pkg::REG_LOOP_COUNT, 8'($urandom_range(1, 6)));
      write_cfg(sspa_pkg::REG_F1_STRONG, 8'(pick_val(-128, 127)));
      write_cfg(sspa_pkg::REG_F1_WEAK, 8'(pick_val(-128, 127)));
      write_cfg(sspa_pkg::REG_PHASE_MIN, 8'(pick_val(0, 127)));
      write_cfg(sspa_pkg::REG_PHASE_MAX, 8'(pick_val(0, 127)));
      cfg_we <= 1'b0;
      // hold off the result side while items keep coming, to fill the core
      if (k == 3) ready_hold = 100;
      run_random(PHASE_ITEMS, k == 3);
      drain();
    end

    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d result items never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
